@@ rtl/vbsw_pkg.sv @@
// vbsw_pkg: shared widths, opcodes, encoding constants and structs
// for the varint byte stream writer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vbsw_pkg;

    localparam int OPCODE_W   = 2;
    localparam int VALUE_W    = 64;
    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 12;
    localparam int CAP_W      = 13;
    localparam int CNT_W      = 2;

    localparam logic [CAP_W-1:0] MAX_CAPACITY = 13'd4096;
    localparam logic [CAP_W-1:0] CAP_RESET    = 13'd4096;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_RAW   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INT32 = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_INT64 = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_FLOAT = 2'd3;

    // remaining byte counts for fixed-width writes
    localparam logic [CNT_W-1:0] CNT_RAW   = 2'd0;
    localparam logic [CNT_W-1:0] CNT_FLOAT = 2'd3;

    localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7f;
    localparam logic [BYTE_W-1:0] CONT_BIT   = 8'h80;
    localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hff;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               last;
        logic [VALUE_W-1:0] next_value;
    } t_shift_res;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              dropped;
    } t_pos_res;

endpackage

`default_nettype wire

@@ rtl/vbsw_if.sv @@
// vbsw_in_if / vbsw_out_if: valid/ready word channels of the writer.
// Depends on vbsw_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vbsw_in_if;
    logic                                valid;
    logic                                ready;
    logic [vbsw_pkg::OPCODE_W-1:0]       opcode;
    logic signed [vbsw_pkg::VALUE_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface vbsw_out_if;
    logic                          valid;
    logic                          ready;
    logic [vbsw_pkg::BYTE_W-1:0]   out_byte;
    logic [vbsw_pkg::ADDR_W-1:0]   write_address;
    logic                          dropped;
    logic                          last_byte;

    modport source (output valid, output out_byte, output write_address,
                    output dropped, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input write_address,
                    input dropped, input last_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/varint_byte_stream_writer.sv @@
// varint_byte_stream_writer: top level, sequencer and output register.
// Depends on vbsw_pkg, vbsw_if, vbsw_shift and vbsw_pos.
`timescale 1ns / 1ps
`default_nettype none

// Takes one word (opcode + 64-bit value) and emits its encoded bytes, one per
// cycle while the output side keeps taking them, each with the buffer address
// it lands at. Raw byte gives 1 byte, float 4 bytes, varints 1 to 10 bytes
// (negative int32 is sign-extended and always gives 10). The word is loaded
// first, then each byte comes out of the shared shift unit. i_word.ready is
// low while a word is being emitted. The output register lets the last byte
// wait while the next input word is accepted. Once the write position reaches
// the capacity (clamped to 4096), bytes come out flagged dropped with address
// 0 and the position holds. Capacity writes (i_cfg_we) are meant to happen
// while idle.
module varint_byte_stream_writer (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [vbsw_pkg::CAP_W-1:0] i_cfg_data,
    vbsw_in_if.sink                         i_word,
    vbsw_out_if.source                      o_word
);

    // sequencer state
    logic                         r_busy, n_busy;
    logic                         r_varint, n_varint;
    logic [vbsw_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [vbsw_pkg::VALUE_W-1:0] r_value, n_value;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic [vbsw_pkg::BYTE_W-1:0]  r_out_byte;
    logic [vbsw_pkg::ADDR_W-1:0]  r_out_addr;
    logic                         r_out_dropped;
    logic                         r_out_last;

    logic                 in_acc;
    logic                 step;
    vbsw_pkg::t_shift_res shift_res;
    vbsw_pkg::t_pos_res   pos_res;

    vbsw_shift u_shift (
        .i_value  (r_value),
        .i_varint (r_varint),
        .i_cnt    (r_cnt),
        .o_res    (shift_res)
    );

    vbsw_pos u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .o_res      (pos_res)
    );

    assign i_word.ready = !r_busy;
    assign in_acc       = i_word.valid && !r_busy;
    // one byte per cycle while the output register is free or being drained
    assign step         = r_busy && (!r_out_valid || o_word.ready);

    always_comb begin
        n_busy      = r_busy;
        n_varint    = r_varint;
        n_cnt       = r_cnt;
        n_value     = r_value;
        n_out_valid = r_out_valid;

        if (o_word.ready) begin
            n_out_valid = 1'b0;
        end

        if (in_acc) begin
            n_busy = 1'b1;
            case (i_word.opcode)
                vbsw_pkg::OP_RAW: begin
                    n_varint = 1'b0;
                    n_cnt    = vbsw_pkg::CNT_RAW;
                    n_value  = i_word.value;
                end
                vbsw_pkg::OP_INT32: begin
                    n_varint = 1'b1;
                    n_cnt    = vbsw_pkg::CNT_RAW;
                    // sign-extend the low 32 bits
                    n_value  = {{32{i_word.value[31]}}, i_word.value[31:0]};
                end
                vbsw_pkg::OP_INT64: begin
                    n_varint = 1'b1;
                    n_cnt    = vbsw_pkg::CNT_RAW;
                    n_value  = i_word.value;
                end
                default: begin
                    n_varint = 1'b0;
                    n_cnt    = vbsw_pkg::CNT_FLOAT;
                    n_value  = i_word.value;
                end
            endcase
        end else if (step) begin
            n_out_valid = 1'b1;
            n_value     = shift_res.next_value;
            n_cnt       = r_cnt - 1'b1;
            if (shift_res.last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_varint <= n_varint;
        r_cnt    <= n_cnt;
        r_value  <= n_value;
        if (step) begin
            r_out_byte    <= shift_res.out_byte;
            r_out_addr    <= pos_res.addr;
            r_out_dropped <= pos_res.dropped;
            r_out_last    <= shift_res.last;
        end
    end

    assign o_word.valid         = r_out_valid;
    assign o_word.out_byte      = r_out_byte;
    assign o_word.write_address = r_out_addr;
    assign o_word.dropped       = r_out_dropped;
    assign o_word.last_byte     = r_out_last;

    // accepted word always starts a run
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_busy)
        else $error("accepted word did not start a run");

    // dropped bytes carry address zero
    a_drop_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_dropped) |-> (r_out_addr == '0))
        else $error("dropped byte with nonzero address");

    // final fixed-width byte ends the run
    a_fixed_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !r_varint && (r_cnt == vbsw_pkg::CNT_RAW)) |=> !r_busy)
        else $error("fixed write did not end on its last byte");

endmodule

`default_nettype wire

@@ rtl/vbsw_shift.sv @@
// vbsw_shift: shared byte extraction and shift unit, one byte per use.
// Depends on vbsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vbsw_shift (
    input  wire logic [vbsw_pkg::VALUE_W-1:0] i_value,
    input  wire logic                         i_varint,
    input  wire logic [vbsw_pkg::CNT_W-1:0]   i_cnt,
    output vbsw_pkg::t_shift_res              o_res
);

    logic more;

    always_comb begin
        more = |i_value[vbsw_pkg::VALUE_W-1:7];
        if (i_varint) begin
            // 7-bit group, continuation bit while more groups follow
            o_res.out_byte   = (i_value[vbsw_pkg::BYTE_W-1:0] & vbsw_pkg::GROUP_MASK)
                               | (more ? vbsw_pkg::CONT_BIT : '0);
            o_res.last       = !more;
            o_res.next_value = i_value >> 7;
        end else begin
            o_res.out_byte   = i_value[vbsw_pkg::BYTE_W-1:0] & vbsw_pkg::BYTE_MASK;
            o_res.last       = (i_cnt == '0);
            o_res.next_value = i_value >> 8;
        end
    end

endmodule

`default_nettype wire

@@ rtl/vbsw_pos.sv @@
// vbsw_pos: capacity register and write position counter.
// Depends on vbsw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vbsw_pos (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [vbsw_pkg::CAP_W-1:0] i_cfg_data,
    input  wire logic                       i_step,
    output vbsw_pkg::t_pos_res              o_res
);

    logic [vbsw_pkg::CAP_W-1:0] r_cap, n_cap;
    logic [vbsw_pkg::CAP_W-1:0] r_pos, n_pos;
    logic [vbsw_pkg::CAP_W-1:0] eff_cap;
    logic                       full;

    always_comb begin
        eff_cap       = (r_cap > vbsw_pkg::MAX_CAPACITY) ? vbsw_pkg::MAX_CAPACITY : r_cap;
        full          = (r_pos >= eff_cap);
        o_res.dropped = full;
        o_res.addr    = full ? '0 : r_pos[vbsw_pkg::ADDR_W-1:0];
        n_cap         = i_cfg_we ? i_cfg_data : r_cap;
        n_pos         = (i_step && !full) ? r_pos + 1'b1 : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= vbsw_pkg::CAP_RESET;
            r_pos <= '0;
        end else begin
            r_cap <= n_cap;
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

@@ dv/vbsw_checker.sv @@
// vbsw_checker: watches the word channels and config port of the varint writer,
// predicts every emitted byte and compares it. Depends on vbsw_pkg and vbsw_if.
`timescale 1ns / 1ps

module vbsw_checker
    import vbsw_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    vbsw_in_if               in_mon,
    vbsw_out_if              out_mon,
    output int               o_err_count,
    output int               o_pending,
    output int               o_words,
    output int               o_bytes,
    output int               o_drops,
    output logic [CAP_W-1:0] o_write_pos
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [ADDR_W-1:0] addr;
        logic              dropped;
        logic              last;
    } enc_byte_t;

    enc_byte_t        byte_q[$];
    logic [CAP_W-1:0] capacity;

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        o_words     = 0;
        o_bytes     = 0;
        o_drops     = 0;
        o_write_pos = '0;
        capacity    = CAP_RESET;
    end

    task automatic note_error(input string msg);
        o_err_count++;
        if (o_err_count <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // one byte into the buffer, or dropped once the position hits the clamped capacity
    task automatic place_byte(input logic [BYTE_W-1:0] b, input logic last);
        logic [CAP_W-1:0] lim;
        enc_byte_t        e;
        lim    = (capacity > MAX_CAPACITY) ? MAX_CAPACITY : capacity;
        e.data = b;
        e.last = last;
        if (o_write_pos >= lim) begin
            e.addr    = '0;
            e.dropped = 1'b1;
        end else begin
            e.addr      = o_write_pos[ADDR_W-1:0];
            e.dropped   = 1'b0;
            o_write_pos = o_write_pos + 1'b1;
        end
        byte_q.push_back(e);
    endtask

    task automatic place_varint(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] rest;
        rest = v;
        while (rest > VALUE_W'(GROUP_MASK)) begin
            place_byte((rest[BYTE_W-1:0] & GROUP_MASK) | CONT_BIT, 1'b0);
            rest = rest >> 7;
        end
        place_byte(rest[BYTE_W-1:0], 1'b1);
    endtask

    task automatic encode_word(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] v);
        case (op)
            OP_RAW:   place_byte(v[BYTE_W-1:0], 1'b1);
            OP_INT32: place_varint({{32{v[31]}}, v[31:0]});
            OP_INT64: place_varint(v);
            default: begin
                for (int i = 0; i < 4; i++)
                    place_byte(v[8*i +: 8], i == 3);
            end
        endcase
    endtask

    task automatic check_byte();
        enc_byte_t exp_b;
        enc_byte_t got_b;
        got_b = '{out_mon.out_byte, out_mon.write_address, out_mon.dropped, out_mon.last_byte};
        o_bytes++;
        if (got_b.dropped === 1'b1)
            o_drops++;
        if (byte_q.size() == 0) begin
            note_error($sformatf("unexpected byte data=%02h addr=%03h drop=%0b last=%0b",
                got_b.data, got_b.addr, got_b.dropped, got_b.last));
        end else begin
            exp_b = byte_q.pop_front();
            if (got_b !== exp_b)
                note_error($sformatf({"byte %0d: expected data=%02h addr=%03h drop=%0b ",
                    "last=%0b, got data=%02h addr=%03h drop=%0b last=%0b"}, o_bytes,
                    exp_b.data, exp_b.addr, exp_b.dropped, exp_b.last,
                    got_b.data, got_b.addr, got_b.dropped, got_b.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity    = CAP_RESET;
            o_write_pos = '0;
            byte_q.delete();
        end else begin
            if (i_cfg_we)
                capacity = i_cfg_data;
            if (in_mon.valid && in_mon.ready) begin
                encode_word(in_mon.opcode, in_mon.value);
                o_words++;
            end
            if (out_mon.valid && out_mon.ready)
                check_byte();
        end
        o_pending = byte_q.size();
    end

endmodule

@@ dv/tb_top.sv @@
// tb_top: stimulus and verdict for varint_byte_stream_writer.
// Depends on vbsw_pkg, vbsw_if, the writer RTL and dv/vbsw_checker.sv.
`timescale 1ns / 1ps

module tb_top;
    import vbsw_pkg::*;

    // settle time after the last expected byte has come out
    localparam int SETTLE = 14;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_data;
    logic             sink_rdy = 1'b0;
    logic             idle_on = 1'b1;   // random idling on both channels

    int               err_count;
    int               pending;
    int               words_seen;
    int               bytes_seen;
    int               drops_seen;
    logic [CAP_W-1:0] pos_view;

    vbsw_in_if  in_if ();
    vbsw_out_if out_if ();

    assign out_if.ready = sink_rdy;

    always #2 clk = ~clk;

    varint_byte_stream_writer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_word     (in_if),
        .o_word     (out_if)
    );

    vbsw_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .in_mon      (in_if),
        .out_mon     (out_if),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_words     (words_seen),
        .o_bytes     (bytes_seen),
        .o_drops     (drops_seen),
        .o_write_pos (pos_view)
    );

    // byte sink: stalls about 36% of cycles while idling is on
    always @(posedge clk) begin
        if (!rst_n)
            sink_rdy <= 1'b0;
        else if (!idle_on)
            sink_rdy <= 1'b1;
        else
            sink_rdy <= ($urandom_range(0, 99) >= 36);
    end

    // Present one word and hold it until accepted. Ready is looked at on the
    // falling edge, where both sides are stable; we return on the accepting
    // rising edge so the next word can follow back to back.
    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] v);
        logic took;
        while (idle_on && $urandom_range(0, 99) < 36) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid  <= 1'b1;
        in_if.opcode <= op;
        in_if.value  <= v;
        do begin
            @(negedge clk);
            took = in_if.ready;
            @(posedge clk);
        end while (!took);
    endtask

    // about half the values are shifted down so every varint length shows up
    function automatic logic [VALUE_W-1:0] rand_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 50)
            v = v >> $urandom_range(1, 63);
        return v;
    endfunction

    task automatic send_random(input int n);
        logic [OPCODE_W-1:0] op;
        for (int i = 0; i < n; i++) begin
            op = OPCODE_W'($urandom_range(OP_RAW, OP_FLOAT));
            send_word(op, rand_value());
        end
    endtask

    // sender holds off until every predicted byte has come out, then lets the
    // pipe settle; ends on a rising edge
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // capacity writes only happen with the block idle
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        in_if.valid  = 1'b0;
        in_if.opcode = OP_RAW;
        in_if.value  = '0;
        cfg_we       = 1'b0;
        cfg_data     = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: field extremes and every opcode ---
        write_capacity(MAX_CAPACITY);
        send_word(OP_RAW,   64'h0);
        send_word(OP_RAW,   64'hffff_ffff_ffff_ffff);   // junk above the byte
        send_word(OP_RAW,   64'h0123_4567_89ab_cd80);
        send_word(OP_INT32, 64'h0);                     // zero varint is one 0x00
        send_word(OP_INT32, 64'h1);
        send_word(OP_INT32, 64'h7f);                    // largest one-byte varint
        send_word(OP_INT32, 64'h80);                    // first two-byte varint
        send_word(OP_INT32, 64'h3fff);
        send_word(OP_INT32, 64'h4000);
        send_word(OP_INT32, 64'h0000_0000_7fff_ffff);
        send_word(OP_INT32, 64'hdead_beef_8000_0000);   // most negative, sign-extends to 10
        send_word(OP_INT32, 64'h0000_0000_ffff_ffff);   // -1
        send_word(OP_INT32, 64'hffff_ffff_0000_0001);   // upper half ignored
        send_word(OP_INT64, 64'h0);
        send_word(OP_INT64, 64'h7f);
        send_word(OP_INT64, 64'h80);
        send_word(OP_INT64, 64'h7fff_ffff_ffff_ffff);
        send_word(OP_INT64, 64'h8000_0000_0000_0000);
        send_word(OP_INT64, 64'hffff_ffff_ffff_ffff);
        send_word(OP_INT64, 64'h00ff_ffff_ffff_ffff);
        send_word(OP_FLOAT, 64'h0);
        send_word(OP_FLOAT, 64'h0000_0000_3f80_0000);
        send_word(OP_FLOAT, 64'hffff_ffff_ffff_ffff);
        send_word(OP_FLOAT, 64'h1234_5678_4049_0fdb);
        wait_idle();

        // --- zero capacity: every byte dropped with address 0 ---
        write_capacity('0);
        send_random(12);
        wait_idle();

        // --- capacity above the limit acts as 4096 ---
        write_capacity('1);
        for (int i = 0; i < 80; i++) begin
            if (i == 30)
                wait_idle();            // sender backs off until all bytes are out
            idle_on = (i < 40);         // idling for the first 40 words, then a long run with no idling on either side
            send_word(OPCODE_W'($urandom_range(OP_RAW, OP_FLOAT)), rand_value());
        end
        idle_on = 1'b1;
        wait_idle();

        // --- capacity lowered below the write position: all dropped ---
        write_capacity(13'd1);
        send_random(10);
        wait_idle();

        // --- buffer fills up in the middle of this phase ---
        write_capacity(pos_view + CAP_W'($urandom_range(3, 40)));
        send_random(20);
        wait_idle();

        // --- room again: position resumes where it stopped ---
        write_capacity(MAX_CAPACITY);
        send_random(24);
        wait_idle();

        // --- burst of ten-byte varints above the clamped capacity ---
        write_capacity('1);
        for (int i = 0; i < 30; i++) begin
            idle_on = (i >= 15);
            send_word(OP_INT64, rand_value() | 64'h8000_0000_0000_0000);
        end
        idle_on = 1'b1;
        wait_idle();
        repeat (20) @(posedge clk);

        $display("Run covered %0d words and %0d bytes, %0d of them dropped,", words_seen,
                 bytes_seen, drops_seen);
        $display("over capacities 0, 1, mid-run, 4096 and 8191 (clamped).");
        if (err_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
